### hdl/vpqs_pkg.sv
// shared types, codes and clip length tables of the voice prompt queue sequencer
package vpqs_pkg;

  localparam int DEF_QUEUE_DEPTH   = 8;
  localparam int DEF_CHINESE_CLIPS = 58;
  localparam int DEF_ENGLISH_CLIPS = 76;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    CMD_SET_ENTRY  = 2'd0,
    CMD_SET_DIGITS = 2'd1,
    CMD_PLAY_FIRST = 2'd2,
    CMD_PLAY_NEXT  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_CHINESE = 2'd1,
    MODE_ENGLISH = 2'd2,
    MODE_ALT     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_PROMPT_MODE  = 2'd0,
    REG_CHINESE_BASE = 2'd1,
    REG_ENGLISH_BASE = 2'd2,
    REG_SPARE        = 2'd3
  } reg_index_t;

  localparam logic [7:0] ENGLISH_BASE_RST = 8'd64;
  localparam logic [7:0] DEFAULT_LEN      = 8'h32;
  localparam logic [7:0] LAST_EXTRA       = 8'd3;

  localparam int ZH_ROM_LEN = 58;
  localparam int EN_ROM_LEN = 76;

  localparam logic [7:0] LEN_ZH [ZH_ROM_LEN] = '{
    8'h32, 8'h32, 8'h32, 8'h37, 8'h37, 8'h32, 8'h32, 8'h32, 8'h32, 8'h37,
    8'h37, 8'h32, 8'h64, 8'h64, 8'h64, 8'h64, 8'h64, 8'h69, 8'h64, 8'h69,
    8'h5A, 8'h5F, 8'h5F, 8'h64, 8'h64, 8'h69, 8'h64, 8'h64, 8'h69, 8'h69,
    8'h69, 8'h64, 8'h64, 8'h6E, 8'h69, 8'h5F, 8'h64, 8'h64, 8'h64, 8'h69,
    8'h69, 8'h69, 8'h64, 8'h69, 8'h64, 8'h64, 8'h55, 8'h5F, 8'h5A, 8'h4B,
    8'h4B, 8'h46, 8'h46, 8'h69, 8'h64, 8'h6E, 8'h5A, 8'h64
  };

  localparam logic [7:0] LEN_EN [EN_ROM_LEN] = '{
    8'h50, 8'h32, 8'h2D, 8'h2D, 8'h2D, 8'h37, 8'h37, 8'h37, 8'h32, 8'h32,
    8'h3C, 8'h37, 8'h46, 8'h46, 8'h4B, 8'h82, 8'h82, 8'h6E, 8'h82, 8'h46,
    8'h96, 8'h64, 8'h46, 8'h6E, 8'h78, 8'h6E, 8'h87, 8'h64, 8'h96, 8'h96,
    8'h46, 8'h9B, 8'h91, 8'h82, 8'h82, 8'h73, 8'h78, 8'h64, 8'h82, 8'h6E,
    8'h78, 8'h82, 8'h87, 8'h6E, 8'h55, 8'h78, 8'h64, 8'h69, 8'h9B, 8'h5A,
    8'h50, 8'h3C, 8'h32, 8'h55, 8'h64, 8'h64, 8'h50, 8'h46, 8'h46, 8'h46,
    8'h4B, 8'h4B, 8'h50, 8'h50, 8'h55, 8'h4B, 8'h4B, 8'h32, 8'h32, 8'h32,
    8'h32, 8'h37, 8'h41, 8'h32, 8'h3C, 8'h37
  };

  function automatic logic [7:0] len_zh(input logic [7:0] id);
    logic [7:0] len;
    len = DEFAULT_LEN;
    if ({1'b0, id} < 9'(ZH_ROM_LEN)) len = LEN_ZH[id[5:0]];
    return len;
  endfunction

  function automatic logic [7:0] len_en(input logic [7:0] id);
    logic [7:0] len;
    len = DEFAULT_LEN;
    if ({1'b0, id} < 9'(EN_ROM_LEN)) len = LEN_EN[id[6:0]];
    return len;
  endfunction

endpackage

### hdl/voice_prompt_queue_sequencer_top.sv
// voice prompt queue sequencer: queue ram, digit split, clip lookup and apb registers
//
// channel | direction | handshake         | payload
// s       | in        | s_tvalid/s_tready | s_tuser command, s_tdata slot..wait_whole
// m       | out       | m_tvalid/m_tready | m_tuser code_valid, m_tlast finished, m_tdata
// apb     | in        | psel/penable      | paddr, pwdata, prdata (prompt mode, bases)
//
// set_entry: decode, done; play commands: decode (queue ram read), evaluate, done;
// set_digits: decode, split states drem to dunit, one push per digit (1 to 3), done
// one command is in work at a time; a new beat is taken while a result waits on m
// rst clears positions, entry valid bits and registers; no clearing pass
// a stalled m side holds the finished result and the next command in its last state
module voice_prompt_queue_sequencer_top #(
  parameter int QUEUE_DEPTH   = vpqs_pkg::DEF_QUEUE_DEPTH,
  parameter int CHINESE_CLIPS = vpqs_pkg::DEF_CHINESE_CLIPS,
  parameter int ENGLISH_CLIPS = vpqs_pkg::DEF_ENGLISH_CLIPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,  // slot, clip_id, number, wait_whole
  input  logic [1:0]                      s_tuser,  // command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,  // voice_code, gap_ticks, digit_count
  output logic                            m_tuser,  // code_valid
  output logic                            m_tlast,  // finished
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vpqs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vpqs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vpqs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  import vpqs_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int PW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DECODE = 10'b0000000010,
    ST_DREM   = 10'b0000000100,
    ST_DHUN   = 10'b0000001000,
    ST_DLOW   = 10'b0000010000,
    ST_DTEN   = 10'b0000100000,
    ST_DUNIT  = 10'b0001000000,
    ST_PUSH   = 10'b0010000000,
    ST_PEVAL  = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [1:0] prompt_mode;
  logic [7:0] chinese_base;
  logic [7:0] english_base;
  logic       cfg_we;
  reg_index_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prompt_mode  <= MODE_OFF;
      chinese_base <= '0;
      english_base <= ENGLISH_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PROMPT_MODE:  prompt_mode  <= pwdata[1:0];
        REG_CHINESE_BASE: chinese_base <= pwdata[7:0];
        REG_ENGLISH_BASE: english_base <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROMPT_MODE:  prdata = {30'd0, prompt_mode};
      REG_CHINESE_BASE: prdata = {24'd0, chinese_base};
      REG_ENGLISH_BASE: prdata = {24'd0, english_base};
      default:          prdata = '0;
    endcase
  end

  // captured command beat
  command_t    it_cmd;
  logic [3:0]  it_slot;
  logic [7:0]  it_clip;
  logic [15:0] it_number;
  logic        it_wait;
  logic        s_accept;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      it_cmd    <= command_t'(s_tuser);
      it_slot   <= s_tdata[3:0];
      it_clip   <= s_tdata[11:4];
      it_number <= s_tdata[27:12];
      it_wait   <= s_tdata[28];
    end
  end

  // queue ram and positions
  logic [PW-1:0]          wr_pos, wr_pos_next;
  logic [PW-1:0]          rd_pos, rd_pos_next;
  logic [QUEUE_DEPTH-1:0] entry_valid;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [7:0]             ram_wdata, ram_rdata;
  logic                   rd_entry_valid;

  vpqs_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // digit split datapath
  logic [6:0]  quot_k;
  logic [9:0]  rem_k;
  logic [3:0]  hund;
  logic [6:0]  low2;
  logic [3:0]  tens;
  logic [3:0]  dig [3];
  logic [1:0]  dig_count;
  logic [1:0]  push_idx;
  logic [26:0] q_prod;
  logic [16:0] k_prod;
  logic [17:0] rem_diff;
  logic [17:0] rem_fix;
  logic [15:0] h_prod;
  logic [10:0] h100;
  logic [9:0]  low_diff;
  logic [13:0] t_prod;
  logic [7:0]  t10;
  logic [7:0]  unit_diff;

  assign q_prod    = 27'(it_number) * 27'd1049;
  assign k_prod    = 17'(quot_k) * 17'd1000;
  assign rem_diff  = {2'b00, it_number} - {1'b0, k_prod};
  assign rem_fix   = rem_diff[17] ? rem_diff + 18'd1000 : rem_diff;
  assign h_prod    = 16'(rem_k) * 16'd41;
  assign h100      = 11'(hund) * 11'd100;
  assign low_diff  = rem_k - h100[9:0];
  assign t_prod    = 14'(low2) * 14'd103;
  assign t10       = 8'(tens) * 8'd10;
  assign unit_diff = {1'b0, low2} - t10;

  // play evaluation
  logic [7:0] play_id;
  logic       mode_on, mode_zh;
  logic       id_ok;
  logic [7:0] base_sel;
  logic [7:0] clip_len;
  logic       play_pre;
  logic       slot_ok;

  assign mode_on  = (prompt_mode != MODE_OFF);
  assign mode_zh  = (prompt_mode == MODE_CHINESE);
  assign play_id  = rd_entry_valid ? ram_rdata : 8'd0;
  assign id_ok    = mode_zh ? ({1'b0, play_id} < 9'(CHINESE_CLIPS))
                            : ({1'b0, play_id} < 9'(ENGLISH_CLIPS));
  assign base_sel = mode_zh ? chinese_base : english_base;
  assign clip_len = mode_zh ? len_zh(play_id) : len_en(play_id);
  assign slot_ok  = (32'(it_slot) < QUEUE_DEPTH);

  // result being built
  logic       res_valid;
  logic [7:0] res_code;
  logic [7:0] res_gap;
  logic       res_fin;
  logic [1:0] res_digits;
  logic       out_load;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (it_cmd == CMD_PLAY_NEXT) ram_raddr = rd_pos[AW-1:0];
    ram_re = (state == ST_DECODE);
  end

  always_comb begin
    state_next  = state;
    wr_pos_next = wr_pos;
    rd_pos_next = rd_pos;
    ram_we      = 1'b0;
    ram_waddr   = AW'(it_slot);
    ram_wdata   = it_clip;
    play_pre    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_accept) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (it_cmd)
          CMD_SET_ENTRY: begin
            if (slot_ok) begin
              ram_we = 1'b1;
              if (it_slot == 4'd0) begin
                rd_pos_next = '0;
                wr_pos_next = PW'(1);
              end else if (wr_pos < PW'(QUEUE_DEPTH)) begin
                wr_pos_next = wr_pos + PW'(1);
              end
            end
            state_next = ST_DONE;
          end
          CMD_SET_DIGITS: begin
            if (it_slot == 4'd0) begin
              wr_pos_next = '0;
              rd_pos_next = '0;
            end
            state_next = ST_DREM;
          end
          default: state_next = ST_PEVAL;
        endcase
      end
      ST_DREM:  state_next = ST_DHUN;
      ST_DHUN:  state_next = ST_DLOW;
      ST_DLOW:  state_next = ST_DTEN;
      ST_DTEN:  state_next = ST_DUNIT;
      ST_DUNIT: state_next = ST_PUSH;
      ST_PUSH: begin
        ram_waddr = wr_pos[AW-1:0];
        ram_wdata = {4'd0, dig[push_idx]};
        if (wr_pos < PW'(QUEUE_DEPTH)) begin
          ram_we      = 1'b1;
          wr_pos_next = wr_pos + PW'(1);
        end
        if (push_idx == dig_count - 2'd1) state_next = ST_DONE;
      end
      ST_PEVAL: begin
        if (it_cmd == CMD_PLAY_FIRST) begin
          play_pre = mode_on && (wr_pos != '0);
          if (play_pre && id_ok && !it_wait) begin
            rd_pos_next = PW'(1);
          end else begin
            wr_pos_next = '0;
            rd_pos_next = '0;
          end
        end else begin
          play_pre = (rd_pos != wr_pos) && mode_on && (rd_pos < PW'(QUEUE_DEPTH));
          if (play_pre && id_ok) begin
            rd_pos_next = rd_pos + PW'(1);
          end else begin
            wr_pos_next = '0;
            rd_pos_next = '0;
          end
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wr_pos      <= '0;
      rd_pos      <= '0;
      entry_valid <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state  <= state_next;
      wr_pos <= wr_pos_next;
      rd_pos <= rd_pos_next;
      if (ram_we) entry_valid[ram_waddr] <= 1'b1;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_DECODE: begin
        rd_entry_valid <= entry_valid[ram_raddr];
        quot_k         <= q_prod[26:20];
        res_valid      <= 1'b0;
        res_code       <= '0;
        res_gap        <= '0;
        res_fin        <= 1'b0;
        res_digits     <= '0;
        push_idx       <= '0;
      end
      ST_DREM:  rem_k <= rem_fix[9:0];
      ST_DHUN:  hund  <= h_prod[15:12];
      ST_DLOW:  low2  <= low_diff[6:0];
      ST_DTEN:  tens  <= t_prod[13:10];
      ST_DUNIT: begin
        if (rem_k >= 10'd100) begin
          dig[0]    <= hund;
          dig[1]    <= tens;
          dig[2]    <= unit_diff[3:0];
          dig_count <= 2'd3;
        end else if (rem_k >= 10'd10) begin
          dig[0]    <= tens;
          dig[1]    <= unit_diff[3:0];
          dig[2]    <= '0;
          dig_count <= 2'd2;
        end else begin
          dig[0]    <= unit_diff[3:0];
          dig[1]    <= '0;
          dig[2]    <= '0;
          dig_count <= 2'd1;
        end
      end
      ST_PUSH: begin
        push_idx   <= push_idx + 2'd1;
        res_digits <= dig_count;
      end
      ST_PEVAL: begin
        if (play_pre && id_ok) begin
          res_valid <= 1'b1;
          res_code  <= play_id + base_sel;
          if (it_cmd == CMD_PLAY_FIRST) begin
            res_gap <= (wr_pos == PW'(1)) ? clip_len + LAST_EXTRA : clip_len;
            res_fin <= it_wait;
          end else begin
            res_gap <= (rd_pos + PW'(1) == wr_pos) ? clip_len + LAST_EXTRA : clip_len;
            res_fin <= 1'b0;
          end
        end else begin
          res_valid <= 1'b0;
          res_code  <= '0;
          res_gap   <= '0;
          res_fin   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_valid;
      m_tlast <= res_fin;
      m_tdata <= {6'd0, res_digits, res_gap, res_code};
    end
  end

  a_wr_pos_range: assert property (@(posedge clk) disable iff (rst)
    wr_pos <= PW'(QUEUE_DEPTH))
    else $error("write position beyond queue depth");

  a_rd_le_wr: assert property (@(posedge clk) disable iff (rst)
    rd_pos <= wr_pos)
    else $error("read position ahead of write position");

  a_no_code_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[15:0] == 16'd0))
    else $error("code or gap set without a voice code");

  a_digits_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:16] != 2'd0) |-> !m_tuser && !m_tlast)
    else $error("digit beat carries a code or run end");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("second command taken while one is in work");

endmodule

### hdl/vpqs_ram.sv
// generic single-port-write ram with registered read
module vpqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
